>>> rtl/core/csp_pkg.sv
// shared types and constants for the color spot tracker
`default_nettype none

package csp_pkg;

    localparam int COORD_W = 9;   // column width at the largest frame
    localparam int ROW_W   = 8;
    localparam int MAP_W   = 27;  // unsaturated mapped coordinate, signed
    localparam int POS_W   = 24;  // signed Q16.8 position

    localparam logic [23:0] TARGET_COLOR_RST   = 24'h00FF00;
    localparam logic [7:0]  DISTANCE_LIMIT_RST = 8'd100;
    localparam logic [7:0]  MIN_BRIGHTNESS_RST = 8'd150;
    localparam logic [15:0] SCALE_RST          = 16'd512;
    localparam logic [12:0] OFFSET_RST         = 13'd0;
    localparam logic [15:0] EASING_GAIN_RST    = 16'd62259;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        CFG_TARGET_COLOR   = 3'd0,
        CFG_DISTANCE_LIMIT = 3'd1,
        CFG_MIN_BRIGHTNESS = 3'd2,
        CFG_SCALE_X        = 3'd3,
        CFG_SCALE_Y        = 3'd4,
        CFG_OFFSET_X       = 3'd5,
        CFG_OFFSET_Y       = 3'd6,
        CFG_EASING_GAIN    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [23:0]        target_color;
        logic [7:0]         distance_limit;
        logic [7:0]         min_brightness;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic signed [12:0] offset_x;
        logic signed [12:0] offset_y;
        logic [15:0]        easing_gain;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] col;
        logic [ROW_W-1:0]   row;
    } pix_t;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    hit;
        logic signed [MAP_W-1:0] map_x;
        logic signed [MAP_W-1:0] map_y;
    } match_t;

    typedef struct packed {
        logic valid;
        logic found;
    } ease_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    found;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/csp_pixel_match.sv
// color distance and brightness test, screen mapping products
`default_nettype none

module csp_pixel_match (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire csp_pkg::cfg_t  cfg,
    input  wire csp_pkg::pix_t  pix,
    output csp_pkg::match_t     match_out
);

    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] sq_r, sq_g, sq_b;
    logic [17:0]        dist2;
    logic [15:0]        limit_sq;
    logic [7:0]         bright;
    logic               hit;
    logic [24:0]        prod_x, prod_y;
    csp_pkg::match_t    match_next;
    csp_pkg::match_t    match_reg;

    always_comb
    begin
        dr = $signed({1'b0, pix.red})   - $signed({1'b0, cfg.target_color[23:16]});
        dg = $signed({1'b0, pix.green}) - $signed({1'b0, cfg.target_color[15:8]});
        db = $signed({1'b0, pix.blue})  - $signed({1'b0, cfg.target_color[7:0]});
        sq_r = dr * dr;
        sq_g = dg * dg;
        sq_b = db * db;
        dist2 = 18'(sq_r[15:0]) + 18'(sq_g[15:0]) + 18'(sq_b[15:0]);
        limit_sq = cfg.distance_limit * cfg.distance_limit;

        bright = pix.red;
        if (pix.green > bright)
        begin
            bright = pix.green;
        end
        if (pix.blue > bright)
        begin
            bright = pix.blue;
        end

        hit = (dist2 < 18'(limit_sq)) && (bright > cfg.min_brightness);

        prod_x = 25'(pix.col) * 25'(cfg.scale_x);
        prod_y = 25'(pix.row) * 25'(cfg.scale_y);

        match_next.valid = pix.valid;
        match_next.last  = pix.last;
        match_next.hit   = hit;
        match_next.map_x = 27'($signed({2'b00, prod_x})) + 27'($signed({cfg.offset_x, 8'h00}));
        match_next.map_y = 27'($signed({2'b00, prod_y})) + 27'($signed({cfg.offset_y, 8'h00}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else if (adv)
        begin
            match_reg <= match_next;
        end
    end

    assign match_out = match_reg;

endmodule

`default_nettype wire

>>> rtl/core/csp_goal_latch.sv
// first match of the frame sets the goal, frame end raises an easing request
`default_nettype none

module csp_goal_latch (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire csp_pkg::match_t                       match_in,
    output logic signed [csp_pkg::POS_W-1:0]           goal_x,
    output logic signed [csp_pkg::POS_W-1:0]           goal_y,
    output csp_pkg::ease_req_t                         req
);

    logic                              hit_reg, hit_next;
    logic signed [csp_pkg::POS_W-1:0]  goal_x_reg, goal_x_next;
    logic signed [csp_pkg::POS_W-1:0]  goal_y_reg, goal_y_next;
    csp_pkg::ease_req_t                req_reg, req_next;

    function automatic logic signed [csp_pkg::POS_W-1:0] sat_pos(
        input logic signed [csp_pkg::MAP_W-1:0] v
    );
        logic signed [csp_pkg::POS_W-1:0] r;
        if (v > csp_pkg::MAP_W'(csp_pkg::POS_MAX))
        begin
            r = csp_pkg::POS_MAX;
        end
        else if (v < csp_pkg::MAP_W'(csp_pkg::POS_MIN))
        begin
            r = csp_pkg::POS_MIN;
        end
        else
        begin
            r = v[csp_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        hit_next    = hit_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        req_next.valid = 1'b0;
        req_next.found = 1'b0;
        if (match_in.valid)
        begin
            if (match_in.hit && !hit_reg)
            begin
                goal_x_next = sat_pos(match_in.map_x);
                goal_y_next = sat_pos(match_in.map_y);
            end
            req_next.valid = match_in.last;
            req_next.found = hit_reg | match_in.hit;
            hit_next = match_in.last ? 1'b0 : (hit_reg | match_in.hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            req_reg    <= '0;
        end
        else if (adv)
        begin
            hit_reg    <= hit_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            req_reg    <= req_next;
        end
    end

    assign goal_x = goal_x_reg;
    assign goal_y = goal_y_reg;
    assign req    = req_reg;

endmodule

`default_nettype wire

>>> rtl/core/csp_smoother.sv
// pointer easing toward the goal, one update per frame
`default_nettype none

module csp_smoother (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire logic [15:0]                           easing_gain,
    input  wire logic signed [csp_pkg::POS_W-1:0]      goal_x,
    input  wire logic signed [csp_pkg::POS_W-1:0]      goal_y,
    input  wire csp_pkg::ease_req_t                    req,
    output logic                                       res_valid,
    output csp_pkg::result_t                           res
);

    logic signed [csp_pkg::POS_W-1:0] smooth_x_reg, smooth_x_next;
    logic signed [csp_pkg::POS_W-1:0] smooth_y_reg, smooth_y_next;

    // step = floor(d * gain / 65536); |step| <= |d| so the sum stays in range
    function automatic logic signed [csp_pkg::POS_W-1:0] ease_step(
        input logic signed [csp_pkg::POS_W-1:0] cur,
        input logic signed [csp_pkg::POS_W-1:0] goal,
        input logic [15:0]                      gain
    );
        logic signed [csp_pkg::POS_W:0]    d;
        logic signed [csp_pkg::POS_W+17:0] prod;
        logic signed [csp_pkg::POS_W+17:0] step;
        logic signed [csp_pkg::POS_W:0]    sum;
        d    = (csp_pkg::POS_W+1)'(goal) - (csp_pkg::POS_W+1)'(cur);
        prod = (csp_pkg::POS_W+18)'(d) * (csp_pkg::POS_W+18)'($signed({1'b0, gain}));
        step = prod >>> 16;
        sum  = (csp_pkg::POS_W+1)'(cur) + step[csp_pkg::POS_W:0];
        return sum[csp_pkg::POS_W-1:0];
    endfunction

    always_comb
    begin
        smooth_x_next = smooth_x_reg;
        smooth_y_next = smooth_y_reg;
        if (req.valid)
        begin
            smooth_x_next = ease_step(smooth_x_reg, goal_x, easing_gain);
            smooth_y_next = ease_step(smooth_y_reg, goal_y, easing_gain);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
        end
        else if (adv)
        begin
            smooth_x_reg <= smooth_x_next;
            smooth_y_reg <= smooth_y_next;
        end
    end

    assign res_valid = adv && req.valid;
    assign res.x     = smooth_x_next;
    assign res.y     = smooth_y_next;
    assign res.found = req.found;

endmodule

`default_nettype wire

>>> rtl/core/csp_result_buf.sv
// two-entry result queue on the output side
`default_nettype none

module csp_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire csp_pkg::result_t  push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output csp_pkg::result_t       out_data
);

    csp_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/core/color_spot_tracker.sv
// top level of the color spot tracker: config, raster counters, pipeline
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata red,green,blue; s_tlast frame_end
//  m_*      out  m_tvalid/m_tready   m_tdata pointer_x,pointer_y; m_tuser spot_found
//  cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one pixel per clock while s_tready is high; a frame result passes, after its last pixel,
// through the input register, match/mapping, goal latch and easing into the result queue
// the easing multiply closes a loop through a single register, the smoothed pointer
// reset clears counters, goal, pointer and the queue; config takes reset values
// s_tready drops only while both result queue entries wait on m_tready
`default_nettype none

module color_spot_tracker #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pointer_x[23:0], pointer_y[47:24]
    output logic             m_tuser,   // spot_found[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

    csp_pkg::cfg_t       cfg_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    csp_pkg::pix_t       pix_reg;
    csp_pkg::match_t     match_s;
    csp_pkg::ease_req_t  req_s;
    csp_pkg::result_t    res_s;
    csp_pkg::result_t    out_s;
    logic signed [csp_pkg::POS_W-1:0] goal_x_s, goal_y_s;
    logic                res_valid_s;
    logic                buf_full;
    logic                adv;
    logic                in_fire;

    assign adv       = !buf_full;
    assign s_tready  = adv;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_color   <= csp_pkg::TARGET_COLOR_RST;
            cfg_reg.distance_limit <= csp_pkg::DISTANCE_LIMIT_RST;
            cfg_reg.min_brightness <= csp_pkg::MIN_BRIGHTNESS_RST;
            cfg_reg.scale_x        <= csp_pkg::SCALE_RST;
            cfg_reg.scale_y        <= csp_pkg::SCALE_RST;
            cfg_reg.offset_x       <= csp_pkg::OFFSET_RST;
            cfg_reg.offset_y       <= csp_pkg::OFFSET_RST;
            cfg_reg.easing_gain    <= csp_pkg::EASING_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (csp_pkg::cfg_index_t'(cfg_index))
                csp_pkg::CFG_TARGET_COLOR:   cfg_reg.target_color   <= cfg_data;
                csp_pkg::CFG_DISTANCE_LIMIT: cfg_reg.distance_limit <= cfg_data[7:0];
                csp_pkg::CFG_MIN_BRIGHTNESS: cfg_reg.min_brightness <= cfg_data[7:0];
                csp_pkg::CFG_SCALE_X:        cfg_reg.scale_x        <= cfg_data[15:0];
                csp_pkg::CFG_SCALE_Y:        cfg_reg.scale_y        <= cfg_data[15:0];
                csp_pkg::CFG_OFFSET_X:       cfg_reg.offset_x       <= cfg_data[12:0];
                csp_pkg::CFG_OFFSET_Y:       cfg_reg.offset_y       <= cfg_data[12:0];
                csp_pkg::CFG_EASING_GAIN:    cfg_reg.easing_gain    <= cfg_data[15:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // raster position of the pixel being accepted
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (s_tlast)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == COL_W'(FRAME_WIDTH - 1))
            begin
                col_next = '0;
                row_next = (row_reg == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pix_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv)
            begin
                pix_reg.valid <= s_tvalid;
                pix_reg.last  <= s_tlast;
                pix_reg.red   <= s_tdata[7:0];
                pix_reg.green <= s_tdata[15:8];
                pix_reg.blue  <= s_tdata[23:16];
                pix_reg.col   <= csp_pkg::COORD_W'(col_reg);
                pix_reg.row   <= csp_pkg::ROW_W'(row_reg);
            end
        end
    end

    csp_pixel_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .pix       (pix_reg),
        .match_out (match_s)
    );

    csp_goal_latch u_goal (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .match_in (match_s),
        .goal_x   (goal_x_s),
        .goal_y   (goal_y_s),
        .req      (req_s)
    );

    csp_smoother u_smooth (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .easing_gain (cfg_reg.easing_gain),
        .goal_x      (goal_x_s),
        .goal_y      (goal_y_s),
        .req         (req_s),
        .res_valid   (res_valid_s),
        .res         (res_s)
    );

    csp_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid_s),
        .push_data (res_s),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_s)
    );

    assign m_tdata = {out_s.y, out_s.x};
    assign m_tuser = out_s.found;

    // input stalls only while results are waiting downstream
    a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // a frame end restarts the raster count
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (col_reg == '0) && (row_reg == '0))
        else $error("raster count not cleared after frame end");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(FRAME_WIDTH - 1))
        else $error("column count out of frame");

    // a result is produced only from a frame-end easing request while the pipeline advances
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_s |-> req_s.valid && adv)
        else $error("result pushed without easing request");

endmodule

`default_nettype wire

>>> bench/color_spot_tracker_checker.sv
// checker for the color spot tracker: predicts each frame result and compares it
`default_nettype none

module color_spot_tracker_checker #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // pointer_x[23:0], pointer_y[47:24]
    input  wire logic        m_tuser,   // spot_found[0]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import csp_pkg::*;

    cfg_t                    regs;
    int unsigned             col_pos;
    int unsigned             row_pos;
    bit                      spot_seen;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [POS_W-1:0] ptr_x;
    logic signed [POS_W-1:0] ptr_y;
    result_t                 frame_q[$];

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // coordinate times Q8.8 scale plus whole-pixel offset, as Q16.8
    function automatic logic signed [POS_W-1:0] place(int unsigned coord, logic [15:0] scale,
                                                     logic signed [12:0] off);
        longint v;
        v = longint'(coord) * longint'(scale) + longint'(off) * 256;
        return clamp_pos(v);
    endfunction

    // one easing step, floor of the Q0.16 product
    function automatic logic signed [POS_W-1:0] glide(logic signed [POS_W-1:0] cur,
                                                     logic signed [POS_W-1:0] goal,
                                                     logic [15:0] gain);
        longint d;
        longint p;
        d = longint'(goal) - longint'(cur);
        p = d * longint'(gain);
        return clamp_pos(longint'(cur) + (p >>> 16));
    endfunction

    task automatic report_miss(string what, longint got, longint want);
        $display("mismatch %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
        fail_count++;
    endtask

    task automatic take_pixel(logic [23:0] px, logic last);
        int          dr;
        int          dg;
        int          db;
        int          bright;
        int unsigned d2;
        int unsigned lim2;
        result_t     e;
        dr = int'(px[7:0])   - int'(regs.target_color[23:16]);
        dg = int'(px[15:8])  - int'(regs.target_color[15:8]);
        db = int'(px[23:16]) - int'(regs.target_color[7:0]);
        d2 = dr * dr + dg * dg + db * db;
        lim2 = int'(regs.distance_limit) * int'(regs.distance_limit);
        bright = int'(px[7:0]);
        if (int'(px[15:8]) > bright)
            bright = int'(px[15:8]);
        if (int'(px[23:16]) > bright)
            bright = int'(px[23:16]);
        if (d2 < lim2 && bright > int'(regs.min_brightness) && !spot_seen)
        begin
            goal_x = place(col_pos, regs.scale_x, regs.offset_x);
            goal_y = place(row_pos, regs.scale_y, regs.offset_y);
            spot_seen = 1'b1;
        end
        if (!last)
        begin
            col_pos++;
            if (col_pos >= FRAME_WIDTH)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= FRAME_HEIGHT)
                    row_pos = 0;
            end
        end
        else
        begin
            ptr_x = glide(ptr_x, goal_x, regs.easing_gain);
            ptr_y = glide(ptr_y, goal_y, regs.easing_gain);
            e.x = ptr_x;
            e.y = ptr_y;
            e.found = spot_seen;
            frame_q = {frame_q, e};
            col_pos = 0;
            row_pos = 0;
            spot_seen = 1'b0;
        end
    endtask

    task automatic check_result();
        result_t want;
        frames_checked++;
        if (frame_q.size() == 0)
        begin
            report_miss("result with no frame pending", longint'($signed(m_tdata[23:0])), 0);
            return;
        end
        want = frame_q.pop_front();
        if (m_tdata[23:0] !== want.x)
            report_miss("pointer_x", longint'($signed(m_tdata[23:0])), longint'(want.x));
        if (m_tdata[47:24] !== want.y)
            report_miss("pointer_y", longint'($signed(m_tdata[47:24])), longint'(want.y));
        if (m_tuser !== want.found)
            report_miss("spot_found", longint'(m_tuser), longint'(want.found));
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        frames_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.target_color   = TARGET_COLOR_RST;
            regs.distance_limit = DISTANCE_LIMIT_RST;
            regs.min_brightness = MIN_BRIGHTNESS_RST;
            regs.scale_x        = SCALE_RST;
            regs.scale_y        = SCALE_RST;
            regs.offset_x       = OFFSET_RST;
            regs.offset_y       = OFFSET_RST;
            regs.easing_gain    = EASING_GAIN_RST;
            col_pos = 0;
            row_pos = 0;
            spot_seen = 1'b0;
            goal_x = '0;
            goal_y = '0;
            ptr_x = '0;
            ptr_y = '0;
            frame_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TARGET_COLOR:   regs.target_color   = cfg_data;
                    CFG_DISTANCE_LIMIT: regs.distance_limit = cfg_data[7:0];
                    CFG_MIN_BRIGHTNESS: regs.min_brightness = cfg_data[7:0];
                    CFG_SCALE_X:        regs.scale_x        = cfg_data[15:0];
                    CFG_SCALE_Y:        regs.scale_y        = cfg_data[15:0];
                    CFG_OFFSET_X:       regs.offset_x       = cfg_data[12:0];
                    CFG_OFFSET_Y:       regs.offset_y       = cfg_data[12:0];
                    CFG_EASING_GAIN:    regs.easing_gain    = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            pending = frame_q.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/color_spot_tracker_tb.sv
// testbench top for the color spot tracker: clock, reset, pixel and register stimulus
`default_nettype none

module color_spot_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csp_pkg::*;

    localparam int W = 320;
    localparam int H = 240;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pointer_x[23:0], pointer_y[47:24]
    logic        m_tuser;   // spot_found[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    int          fail_count;
    int          pending;
    int          frames_checked;

    logic [23:0] cur_target;
    bit          calm;
    bit          hold_start;
    int          hold_left;
    int          pixels_sent;
    int          frames_sent;
    int          settings_used;

    color_spot_tracker #(
        .FRAME_WIDTH (W),
        .FRAME_HEIGHT(H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    color_spot_tracker_checker #(
        .FRAME_WIDTH (W),
        .FRAME_HEIGHT(H)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .frames_checked(frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL color_spot_tracker");
        $finish;
    end

    // result side: random backpressure, a long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // leaves cfg_valid high, the caller lowers it after the last write
    task automatic put_reg(cfg_index_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(logic [23:0] rgb, logic last);
        while (!calm && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    // drop the request and wait for every frame result, plus pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    function automatic logic [7:0] nudge(logic [7:0] c, int k);
        int v;
        v = int'(c) + int'($urandom_range(2 * k)) - k;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic logic [23:0] near_target(int k);
        return {nudge(cur_target[23:16], k), nudge(cur_target[15:8], k),
                nudge(cur_target[7:0], k)};
    endfunction

    // pixels before hit_at are black or noise, hit_at itself sits near the target
    task automatic send_frame(int len, int hit_at, bit dark, int k);
        logic [23:0] px;
        for (int i = 0; i < len; i++)
        begin
            if (i < hit_at)
                px = dark ? 24'h000000 : 24'($urandom);
            else if (i == hit_at)
                px = near_target(k);
            else
                px = ($urandom_range(1) == 1) ? near_target(k) : 24'($urandom);
            send_pixel(px, i == len - 1);
        end
        frames_sent++;
    endtask

    task automatic new_setting(int phase);
        logic [23:0]        tc;
        logic [7:0]         dl;
        logic [7:0]         mb;
        logic [15:0]        sx;
        logic [15:0]        sy;
        logic signed [12:0] ox;
        logic signed [12:0] oy;
        logic [15:0]        eg;
        tc = 24'($urandom);
        dl = 8'($urandom_range(255));
        mb = 8'($urandom_range(220));
        sx = 16'($urandom);
        sy = 16'($urandom);
        ox = 13'($urandom);
        oy = 13'($urandom);
        eg = 16'($urandom);
        case (phase)
            0:
            begin
                tc = 24'hFFFFFF;
                dl = 8'd255;
                mb = 8'd0;
                sx = 16'hFFFF;
                sy = 16'hFFFF;
                ox = 13'sd4095;
                oy = 13'sd4095;
                eg = 16'hFFFF;
            end
            1:
            begin
                tc = 24'h000000;
                dl = 8'd255;
                mb = 8'd0;
                sx = 16'h0000;
                sy = 16'h0000;
                ox = 13'sh1000;
                oy = 13'sh1000;
                eg = 16'h0000;
            end
            2:
            begin
                dl = 8'd0;
                mb = 8'd255;
            end
            4:
            begin
                // the row-crossing frame needs its spot to match
                tc = tc | 24'h400000;
                dl = 8'($urandom_range(255, 50));
                mb = 8'd0;
            end
            default: ;
        endcase
        cur_target = tc;
        put_reg(CFG_TARGET_COLOR, tc);
        put_reg(CFG_DISTANCE_LIMIT, {16'h0, dl});
        put_reg(CFG_MIN_BRIGHTNESS, {16'h0, mb});
        put_reg(CFG_SCALE_X, {8'h0, sx});
        put_reg(CFG_SCALE_Y, {8'h0, sy});
        put_reg(CFG_OFFSET_X, {11'h0, ox});
        put_reg(CFG_OFFSET_Y, {11'h0, oy});
        put_reg(CFG_EASING_GAIN, {8'h0, eg});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int phase;
        int rand_pixels;
        int phase_pixels;
        int len;
        int hit_at;
        int k;
        int guard;
        bit dark;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TARGET_COLOR;
        cfg_data = '0;
        calm = 1'b0;
        hold_start = 1'b0;
        pixels_sent = 0;
        frames_sent = 0;
        settings_used = 1;
        cur_target = TARGET_COLOR_RST;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: first match wins, a later match is ignored
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h00FF00, 1'b1);
        // distance exactly at the limit, then one below on the last pixel
        send_pixel(24'h009B00, 1'b0);
        send_pixel(24'h009C00, 1'b1);
        // frame with no match still eases toward the old goal
        send_pixel(24'h0A141E, 1'b1);
        settle();
        put_reg(CFG_DISTANCE_LIMIT, 24'd0);
        cfg_valid <= 1'b0;
        send_pixel(24'h00FF00, 1'b1);
        settle();
        put_reg(CFG_DISTANCE_LIMIT, 24'd255);
        put_reg(CFG_MIN_BRIGHTNESS, 24'd155);
        cfg_valid <= 1'b0;
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h009C00, 1'b1);
        settle();
        // brightness equal to the bound does not match
        put_reg(CFG_MIN_BRIGHTNESS, 24'd156);
        cfg_valid <= 1'b0;
        send_pixel(24'h009C00, 1'b1);

        phase = 0;
        rand_pixels = 0;
        while (phase < 5 || rand_pixels < 400)
        begin
            settle();
            new_setting(phase);
            // the row-crossing phase runs with no idling on either side
            calm = (phase == 4);
            if (phase == 0)
            begin
                // late spot on the first row drives the mapping into saturation
                send_frame(120, 115, 1'b1, 10);
                rand_pixels += 120;
            end
            if (phase == 3)
            begin
                hold_start = 1'b1;
                repeat (12)
                    send_frame(1, 0, 1'b0, 3);
                rand_pixels += 12;
            end
            if (phase == 4)
            begin
                // first spot sits on the second row
                send_frame(W + 5, W + 2, 1'b1, 0);
                rand_pixels += W + 5;
            end
            phase_pixels = 0;
            while (phase_pixels < 12)
            begin
                len = $urandom_range(8, 1);
                dark = $urandom_range(1);
                hit_at = ($urandom_range(4) == 0) ? len : $urandom_range(len - 1);
                k = $urandom_range(40);
                send_frame(len, hit_at, dark, k);
                phase_pixels += len;
                rand_pixels += len;
            end
            phase++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20)
            @(negedge clk);
        $display("covered %0d pixels in %0d frames, %0d frame results, %0d register settings",
                 pixels_sent, frames_sent, frames_checked, settings_used);
        $display("included saturated mapping, a spot past the first row and a result hold-off");
        if (fail_count == 0 && pending == 0)
            $display("PASS color_spot_tracker");
        else
            $display("FAIL color_spot_tracker");
        $finish;
    end

endmodule

`default_nettype wire
